/* sv/assert_macros.svh */
// Assertion macros for the checks in this block's top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CLFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true outside reset.
`define CLFW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/clfw_pkg.sv */
// Types, codes and helper functions shared by the character LCD frame writer.
package clfw_pkg;

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_POS  = 2'd2
  } kind_t;

  // Wrap mode register codes; the fourth code acts as plain.
  localparam logic [1:0] WRAP_PLAIN = 2'd0;
  localparam logic [1:0] WRAP_NEXT  = 2'd1;
  localparam logic [1:0] WRAP_STOP  = 2'd2;

  // Frame bytes.
  localparam logic [7:0] SYNC_CMD  = 8'hF8;
  localparam logic [7:0] SYNC_DAT  = 8'hFA;
  localparam logic [7:0] NIB_MASK  = 8'hF0;
  localparam logic [7:0] ADDR_BASE = 8'h80;

  // Byte index of the last byte of a one-frame and a two-frame run.
  localparam logic [2:0] LAST_ONE_FRAME  = 3'd2;
  localparam logic [2:0] LAST_TWO_FRAMES = 3'd5;

  // One queued run of frames: a first frame, an optional command frame, and
  // the cursor address reported on every byte of the run.
  typedef struct packed {
    logic       first_is_data;
    logic [7:0] first_payload;
    logic       two_frames;
    logic [7:0] second_payload;
    logic [5:0] cursor;
  } frame_desc_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Display address where each row begins.
  function automatic logic [5:0] row_base(input logic [1:0] row);
    logic [5:0] base;
    case (row)
      2'd0:    base = 6'h00;
      2'd1:    base = 6'h10;
      2'd2:    base = 6'h08;
      default: base = 6'h18;
    endcase
    return base;
  endfunction

  // True when a stepped address has run off the end of a row.
  function automatic logic is_row_end(input logic [5:0] addr);
    return addr inside {6'h08, 6'h10, 6'h18, 6'h20};
  endfunction

  // Start of the next display row, in display order, after a row end.
  function automatic logic [5:0] next_row_start(input logic [5:0] addr);
    logic [5:0] start;
    case (addr)
      6'h08:   start = 6'h10;
      6'h10:   start = 6'h18;
      6'h18:   start = 6'h08;
      default: start = 6'h00;
    endcase
    return start;
  endfunction

endpackage

/* sv/char_lcd_serial_frame_writer_top.sv */
// Top level of the character LCD serial frame writer.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_stall     in_kind, in_value, in_row, in_column
//   out      output     out_valid / out_stall   out_serial_byte, out_last_of_run,
//                                               out_cursor_address
//   cfg      input      cfg_valid / cfg_ready   cfg_wrap_mode
//
// Each item becomes three bytes, or six when a row wrap adds a set-address frame,
// sent by the byte sequencer at one byte per cycle while the output is not stalled.
// Items that cause no bytes are taken without using the queue.
// The front end takes a new item each cycle while the run queue has room.
// Reset is synchronous and active low; it clears the address state and the queue.
// A stalled output holds its byte; the front end keeps working until the queue fills.
`include "assert_macros.svh"

module char_lcd_serial_frame_writer_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_value,
  input  logic [1:0] in_row,
  input  logic [2:0] in_column,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_serial_byte,
  output logic       out_last_of_run,
  output logic [5:0] out_cursor_address,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_wrap_mode
);

  clfw_pkg::frame_desc_t push_desc;
  clfw_pkg::frame_desc_t head_desc;
  clfw_pkg::q_status_t   q_status;
  logic                  push;
  logic                  pop;

  // The wrap mode register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  clfw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .in_row        (in_row),
    .in_column     (in_column),
    .cfg_valid     (cfg_valid),
    .cfg_wrap_mode (cfg_wrap_mode),
    .q_status      (q_status),
    .push          (push),
    .push_desc     (push_desc)
  );

  clfw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .q_status  (q_status)
  );

  clfw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_desc          (head_desc),
    .q_status           (q_status),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_serial_byte    (out_serial_byte),
    .out_last_of_run    (out_last_of_run),
    .out_cursor_address (out_cursor_address)
  );

  // The queue can never look full and empty at once.
  `CLFW_NEVER(a_queue_status, q_status.full && q_status.empty, "queue full and empty")
  // The front end never pushes into a full queue.
  `CLFW_NEVER(a_push_full, push && q_status.full, "push into full queue")
  // Inside a run the next byte follows at once with the same cursor address.
  `CLFW_ASSERT(a_run_cont, (out_valid && !out_stall && !out_last_of_run) |=> (out_valid && $stable(out_cursor_address)), "run broken")

endmodule

/* sv/clfw_front.sv */
// Front end: accepts items, tracks the display address and queues frame runs.
module clfw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [7:0]           in_value,
  input  logic [1:0]           in_row,
  input  logic [2:0]           in_column,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_wrap_mode,
  input  clfw_pkg::q_status_t  q_status,
  output logic                 push,
  output clfw_pkg::frame_desc_t push_desc
);

  logic [1:0] wrap_mode_r;
  logic [5:0] addr_r, addr_nxt;
  logic       half_r, half_nxt;
  logic       blocked_r, blocked_nxt;
  logic       accept;
  logic       emit;
  logic [5:0] pos_addr;
  logic [5:0] step_addr;
  logic [5:0] wrap_addr;

  // The front only waits when the queue has no room.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && emit;

  assign pos_addr  = clfw_pkg::row_base(in_row) + {3'b000, in_column};
  assign step_addr = addr_r + 6'd1;
  assign wrap_addr = clfw_pkg::next_row_start(step_addr);

  // Classify the item and work out the new address state.
  always_comb begin
    emit        = 1'b0;
    addr_nxt    = addr_r;
    half_nxt    = half_r;
    blocked_nxt = blocked_r;
    push_desc.first_is_data  = 1'b0;
    push_desc.first_payload  = in_value;
    push_desc.two_frames     = 1'b0;
    push_desc.second_payload = clfw_pkg::ADDR_BASE + {2'b00, wrap_addr};
    case (in_kind)
      clfw_pkg::KIND_CMD: begin
        emit = 1'b1;
      end
      clfw_pkg::KIND_POS: begin
        emit        = 1'b1;
        addr_nxt    = pos_addr;
        half_nxt    = 1'b0;
        blocked_nxt = 1'b0;
        push_desc.first_payload = clfw_pkg::ADDR_BASE + {2'b00, pos_addr};
      end
      clfw_pkg::KIND_DATA: begin
        if (!(blocked_r && wrap_mode_r == clfw_pkg::WRAP_STOP)) begin
          emit = 1'b1;
          push_desc.first_is_data = 1'b1;
          if (half_r) begin
            half_nxt = 1'b0;
            addr_nxt = step_addr;
            if (clfw_pkg::is_row_end(step_addr)) begin
              if (wrap_mode_r == clfw_pkg::WRAP_NEXT) begin
                addr_nxt             = wrap_addr;
                push_desc.two_frames = 1'b1;
              end else if (wrap_mode_r == clfw_pkg::WRAP_STOP) begin
                blocked_nxt = 1'b1;
              end
            end
          end else begin
            half_nxt = 1'b1;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    push_desc.cursor = addr_nxt;
  end

  // Address state is updated on every accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= '0;
      half_r    <= 1'b0;
      blocked_r <= 1'b0;
    end else if (accept) begin
      addr_r    <= addr_nxt;
      half_r    <= half_nxt;
      blocked_r <= blocked_nxt;
    end
  end

  // Wrap mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_mode_r <= clfw_pkg::WRAP_PLAIN;
    end else if (cfg_valid) begin
      wrap_mode_r <= cfg_wrap_mode;
    end
  end

endmodule

/* sv/clfw_queue.sv */
// Short queue of frame runs between the front end and the byte sequencer.
module clfw_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  clfw_pkg::frame_desc_t push_desc,
  input  logic                  pop,
  output clfw_pkg::frame_desc_t head_desc,
  output clfw_pkg::q_status_t   q_status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  clfw_pkg::frame_desc_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head_desc      = entries_r[rd_ptr_r];
  assign q_status.full  = (count_r == CNT_W'(DEPTH));
  assign q_status.empty = (count_r == '0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

/* sv/clfw_back.sv */
// Back end: walks each queued run and sends one frame byte per cycle while the output is not stalled.
module clfw_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  clfw_pkg::frame_desc_t head_desc,
  input  clfw_pkg::q_status_t   q_status,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_serial_byte,
  output logic                  out_last_of_run,
  output logic [5:0]            out_cursor_address
);

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_serial_byte_r;
  logic       out_last_of_run_r;
  logic [5:0] out_cursor_address_r;
  logic       slot_free;
  logic       load;
  logic [7:0] byte_sel;
  logic       last_sel;

  assign slot_free = !out_valid_r || !out_stall;
  assign load      = slot_free && !q_status.empty;
  assign pop       = load && last_sel;

  // Pick the byte of the head run at the current index.
  always_comb begin
    last_sel = 1'b0;
    case (idx_r)
      3'd0: byte_sel = head_desc.first_is_data ? clfw_pkg::SYNC_DAT : clfw_pkg::SYNC_CMD;
      3'd1: byte_sel = head_desc.first_payload & clfw_pkg::NIB_MASK;
      3'd2: byte_sel = {head_desc.first_payload[3:0], 4'h0};
      3'd3: byte_sel = clfw_pkg::SYNC_CMD;
      3'd4: byte_sel = head_desc.second_payload & clfw_pkg::NIB_MASK;
      3'd5: byte_sel = {head_desc.second_payload[3:0], 4'h0};
      default: byte_sel = clfw_pkg::SYNC_CMD;
    endcase
    if (head_desc.two_frames) begin
      last_sel = (idx_r == clfw_pkg::LAST_TWO_FRAMES);
    end else begin
      last_sel = (idx_r == clfw_pkg::LAST_ONE_FRAME);
    end
  end

  // Index and output valid update.
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (slot_free) begin
      out_valid_nxt = load;
    end
    if (load) begin
      idx_nxt = last_sel ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_serial_byte_r    <= byte_sel;
      out_last_of_run_r    <= last_sel;
      out_cursor_address_r <= head_desc.cursor;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_serial_byte    = out_serial_byte_r;
  assign out_last_of_run    = out_last_of_run_r;
  assign out_cursor_address = out_cursor_address_r;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the character LCD serial frame writer.
module tb_top;

  // Cycles without any accepted item or byte before the run is called hung.
  localparam int STALL_LIMIT   = 1000;
  // Cycles to let a dropped item clear the block before it is treated as idle.
  localparam int SETTLE_CYCLES = 10;

  // One serial byte as the block should emit it.
  typedef struct {
    logic [7:0] serial_byte;
    logic       last_of_run;
    logic [5:0] cursor;
  } lcd_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_kind = clfw_pkg::KIND_CMD;
  logic [7:0] in_value = 8'h00;
  logic [1:0] in_row = 2'd0;
  logic [2:0] in_column = 3'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_serial_byte;
  logic       out_last_of_run;
  logic [5:0] out_cursor_address;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_wrap_mode = clfw_pkg::WRAP_PLAIN;

  // Shadow of the block's address state and its wrap mode register.
  logic [5:0] cur_addr = 6'd0;
  logic       half_cell = 1'b0;
  logic       row_locked = 1'b0;
  logic [1:0] wrap_sel = clfw_pkg::WRAP_PLAIN;

  lcd_byte_t  expected_bytes[$];
  logic [7:0] run_bytes[$];
  int         fault_count = 0;
  int         productive_items = 0;
  int         idle_cycles = 0;
  int         hold_len = 0;
  bit         no_idle = 1'b0;

  char_lcd_serial_frame_writer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .in_row            (in_row),
    .in_column         (in_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_serial_byte   (out_serial_byte),
    .out_last_of_run   (out_last_of_run),
    .out_cursor_address(out_cursor_address),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_wrap_mode     (cfg_wrap_mode)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Display offset where each row starts; rows are interleaved in memory.
  function automatic logic [5:0] row_start(input logic [1:0] row);
    case (row)
      2'd0:    return 6'h00;
      2'd1:    return 6'h10;
      2'd2:    return 6'h08;
      default: return 6'h18;
    endcase
  endfunction

  // A frame is the sync byte followed by the two nibbles, each in the top half.
  function automatic void add_frame(input logic [7:0] sync, input logic [7:0] payload);
    run_bytes.push_back(sync);
    run_bytes.push_back(payload & clfw_pkg::NIB_MASK);
    run_bytes.push_back({payload[3:0], 4'h0});
  endfunction

  // Work out the bytes one accepted item causes and queue them as expected.
  function automatic void predict_lcd_bytes(input logic [1:0] kind, input logic [7:0] value,
                                            input logic [1:0] row, input logic [2:0] column);
    logic [5:0] next_start;
    logic       at_row_end;
    lcd_byte_t  exp_byte;
    next_start = 6'h00;
    at_row_end = 1'b1;
    run_bytes.delete();
    case (kind)
      clfw_pkg::KIND_CMD: add_frame(clfw_pkg::SYNC_CMD, value);
      clfw_pkg::KIND_POS: begin
        cur_addr   = row_start(row) + {3'b000, column};
        half_cell  = 1'b0;
        row_locked = 1'b0;
        add_frame(clfw_pkg::SYNC_CMD, clfw_pkg::ADDR_BASE + {2'b00, cur_addr});
      end
      clfw_pkg::KIND_DATA: begin
        // A locked row in stop mode swallows the byte without a trace.
        if (!(row_locked && wrap_sel == clfw_pkg::WRAP_STOP)) begin
          add_frame(clfw_pkg::SYNC_DAT, value);
          if (half_cell) begin
            half_cell = 1'b0;
            cur_addr  = cur_addr + 6'd1;
            case (cur_addr)
              6'h08:   next_start = 6'h10;
              6'h10:   next_start = 6'h18;
              6'h18:   next_start = 6'h08;
              6'h20:   next_start = 6'h00;
              default: at_row_end = 1'b0;
            endcase
            if (at_row_end) begin
              if (wrap_sel == clfw_pkg::WRAP_NEXT) begin
                cur_addr = next_start;
                add_frame(clfw_pkg::SYNC_CMD, clfw_pkg::ADDR_BASE + {2'b00, cur_addr});
              end else if (wrap_sel == clfw_pkg::WRAP_STOP) begin
                row_locked = 1'b1;
              end
            end
          end else begin
            half_cell = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (run_bytes.size() != 0) productive_items++;
    foreach (run_bytes[i]) begin
      exp_byte.serial_byte = run_bytes[i];
      exp_byte.last_of_run = (i == run_bytes.size() - 1);
      exp_byte.cursor      = cur_addr;
      expected_bytes.push_back(exp_byte);
    end
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Compare one accepted byte against the oldest expectation.
  function automatic void check_lcd_byte();
    lcd_byte_t want;
    if (expected_bytes.size() == 0) begin
      fault_count++;
      $display("%0t: byte with nothing expected, expected none, actual %0h",
               $time, out_serial_byte);
    end else begin
      want = expected_bytes.pop_front();
      compare_field("serial_byte", want.serial_byte, out_serial_byte);
      compare_field("last_of_run", want.last_of_run, out_last_of_run);
      compare_field("cursor_address", want.cursor, out_cursor_address);
    end
  endfunction

  // Both channels are observed at the clock edge, inputs first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_lcd_bytes(in_kind, in_value, in_row, in_column);
      if (out_valid && !out_stall) check_lcd_byte();
    end
  end

  // Watchdog on cycles in which nothing moves on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: a random stall before each byte, or a long hold when one is requested.
  initial begin
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 9);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_item(input clfw_pkg::kind_t kind, input logic [7:0] value,
                           input logic [1:0] row, input logic [2:0] column);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_value  <= value;
    in_row    <= row;
    in_column <= column;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait for every expected byte, then let the block settle.
  // The first edge lets the last accepted item reach the expected queue.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_wrap_mode(input logic [1:0] mode);
    wait_drained();
    cfg_valid     <= 1'b1;
    cfg_wrap_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wrap_sel = mode;
  endtask

  // Mostly position-then-data runs long enough to reach row ends, plus loose items.
  task automatic random_run(input int n_items);
    int goal;
    int len;
    int pick;
    goal = productive_items + n_items;
    while (productive_items < goal) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(clfw_pkg::KIND_CMD, 8'($urandom_range(0, 255)), 2'($urandom),
                  3'($urandom));
      end else if (pick == 1) begin
        send_item(clfw_pkg::KIND_DATA, 8'($urandom_range(0, 255)), 2'($urandom),
                  3'($urandom));
      end else begin
        send_item(clfw_pkg::KIND_POS, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                  3'($urandom_range(0, 7)));
        len = $urandom_range(1, 18);
        repeat (len) begin
          if ($urandom_range(0, 11) == 0)
            send_item(clfw_pkg::KIND_CMD, 8'($urandom_range(0, 255)), 2'($urandom),
                      3'($urandom));
          else
            send_item(clfw_pkg::KIND_DATA, 8'($urandom_range(0, 255)), 2'($urandom),
                      3'($urandom));
        end
      end
    end
  endtask

  // Command bytes at the extremes, positions at the corners, data in plain mode.
  task automatic test_commands_and_positions();
    set_wrap_mode(clfw_pkg::WRAP_PLAIN);
    send_item(clfw_pkg::KIND_CMD, 8'h00, 2'd0, 3'd0);
    send_item(clfw_pkg::KIND_CMD, 8'hFF, 2'd3, 3'd7);
    send_item(clfw_pkg::KIND_POS, 8'h00, 2'd0, 3'd0);
    send_item(clfw_pkg::KIND_POS, 8'hFF, 2'd3, 3'd7);
    send_item(clfw_pkg::KIND_DATA, 8'h00, 2'd0, 3'd0);
    send_item(clfw_pkg::KIND_DATA, 8'hFF, 2'd3, 3'd7);
    send_item(clfw_pkg::KIND_CMD, 8'hA5, 2'd1, 3'd2);
  endtask

  // Finishing the last cell of each row jumps to the next row in display order.
  task automatic test_row_wrap();
    set_wrap_mode(clfw_pkg::WRAP_NEXT);
    for (int r = 0; r < 4; r++) begin
      send_item(clfw_pkg::KIND_POS, 8'h00, 2'(r), 3'd7);
      send_item(clfw_pkg::KIND_DATA, 8'h0F, 2'd0, 3'd0);
      send_item(clfw_pkg::KIND_DATA, 8'hF0, 2'd0, 3'd0);
    end
  endtask

  // Stop mode locks the row; a command leaves the lock, a position clears it.
  task automatic test_row_stop();
    set_wrap_mode(clfw_pkg::WRAP_STOP);
    send_item(clfw_pkg::KIND_POS, 8'h00, 2'd0, 3'd7);
    send_item(clfw_pkg::KIND_DATA, 8'h31, 2'd0, 3'd0);
    send_item(clfw_pkg::KIND_DATA, 8'h32, 2'd0, 3'd0);
    send_item(clfw_pkg::KIND_DATA, 8'h33, 2'd0, 3'd0);
    send_item(clfw_pkg::KIND_CMD, 8'h0C, 2'd0, 3'd0);
    send_item(clfw_pkg::KIND_DATA, 8'h34, 2'd0, 3'd0);
    send_item(clfw_pkg::KIND_POS, 8'h00, 2'd1, 3'd0);
    send_item(clfw_pkg::KIND_DATA, 8'h35, 2'd0, 3'd0);
  endtask

  // Random traffic in every mode, with and without idle cycles on either side.
  task automatic test_random_traffic();
    logic [1:0] modes[3];
    modes = '{clfw_pkg::WRAP_PLAIN, clfw_pkg::WRAP_NEXT, clfw_pkg::WRAP_STOP};
    foreach (modes[m]) begin
      set_wrap_mode(modes[m]);
      random_run(15);
      wait_drained();
      no_idle = 1'b1;
      random_run(10);
      no_idle = 1'b0;
    end
  endtask

  // A long plain run from the last cell carries the address past 63 back to 0.
  task automatic test_address_rollover();
    set_wrap_mode(clfw_pkg::WRAP_PLAIN);
    send_item(clfw_pkg::KIND_POS, 8'h00, 2'd3, 3'd7);
    repeat (68) send_item(clfw_pkg::KIND_DATA, 8'($urandom_range(0, 255)), 2'd0, 3'd0);
  endtask

  // The receiver holds off while items keep coming, so the block must stall its input.
  task automatic test_backpressure();
    set_wrap_mode(clfw_pkg::WRAP_NEXT);
    hold_len = 80;
    no_idle  = 1'b1;
    send_item(clfw_pkg::KIND_POS, 8'h00, 2'd2, 3'd4);
    repeat (10) send_item(clfw_pkg::KIND_DATA, 8'($urandom_range(0, 255)), 2'd0, 3'd0);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands_and_positions();
    test_row_wrap();
    test_row_stop();
    test_random_traffic();
    test_address_rollover();
    test_backpressure();
    wait_drained();
    if (expected_bytes.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
